FILE: rtl/lsp_pkg.sv
`timescale 1ns / 1ps

package lsp_pkg;

   localparam int DEF_STORE_WORDS  = 65536;
   localparam int DEF_SAMPLE_BITS  = 16;
   localparam int MAX_SAMPLE_BITS  = 24;

   localparam int LEN_BITS         = 17;
   localparam int POS_BITS         = 16;
   localparam int SEEK_BITS        = 24;
   localparam int MIX_BITS         = 16;
   localparam int GAIN_BITS        = 15;
   localparam int GAIN_FRAC        = 14;
   localparam int ROUND_HALF       = 8192;
   localparam int MAX_LOOP         = 65536;
   localparam int MIX_MAX          = 32767;
   localparam int MIX_MIN          = -32768;
   localparam int QUEUE_DEPTH      = 2;

   localparam int REQ_DATA_BITS    = 88;
   localparam int RSP_DATA_BITS    = 48;
   localparam int OP_BITS          = 2;
   localparam int CSR_INDEX_BITS   = 2;

   localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_BITS-1:0] OP_RENDER = 2'd1;
   localparam logic [OP_BITS-1:0] OP_SEEK   = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEREO  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOOP    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REVERSE = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN    = 2'd3;

   localparam logic [LEN_BITS-1:0]  LOOP_RESET = 17'd65536;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd16384;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_RENDER,
      CMD_SEEK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [15:0]                load_address;
      logic signed [15:0]         load_sample;
      logic                       seek_neg;
      logic [SEEK_BITS-1:0]       seek_mag;
      logic signed [MIX_BITS-1:0] left_mix;
      logic signed [MIX_BITS-1:0] right_mix;
   } cmd_type;

   typedef struct packed {
      logic                 stereo_mode;
      logic                 reverse_play;
      logic [GAIN_BITS-1:0] gain;
      logic [LEN_BITS-1:0]  loop_len;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEEK,
      ST_WRAP,
      ST_RD_L,
      ST_RD_R,
      ST_MUL,
      ST_MIX
   } back_state_type;

endpackage

FILE: rtl/lsp_ram.sv
`timescale 1ns / 1ps

module lsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lsp_front.sv
`timescale 1ns / 1ps

module lsp_front #(
   parameter int STORE_WORDS = lsp_pkg::DEF_STORE_WORDS
) (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [lsp_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  logic [lsp_pkg::OP_BITS-1:0]        req_tuser,
   input  logic                               queue_full,
   output logic                               push,
   output lsp_pkg::cmd_type                   cmd
);

   logic [15:0]                     addr;
   logic signed [23:0]              seek_pos;
   logic                            keep;

   assign addr     = req_tdata[15:0];
   assign seek_pos = $signed(req_tdata[55:32]);

   assign req_tready = !queue_full;

   always_comb begin
      cmd.kind         = lsp_pkg::CMD_LOAD;
      cmd.load_address = addr;
      cmd.load_sample  = $signed(req_tdata[31:16]);
      cmd.seek_neg     = seek_pos[23];
      cmd.seek_mag     = seek_pos[23] ? 24'(24'd0 - req_tdata[55:32]) : req_tdata[55:32];
      cmd.left_mix     = $signed(req_tdata[71:56]);
      cmd.right_mix    = $signed(req_tdata[87:72]);
      keep             = 1'b0;
      case (req_tuser)
         lsp_pkg::OP_LOAD: begin
            cmd.kind = lsp_pkg::CMD_LOAD;
            // loads beyond the store are dropped here
            keep     = (32'(addr) < 32'(STORE_WORDS));
         end
         lsp_pkg::OP_RENDER: begin
            cmd.kind = lsp_pkg::CMD_RENDER;
            keep     = 1'b1;
         end
         lsp_pkg::OP_SEEK: begin
            cmd.kind = lsp_pkg::CMD_SEEK;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && !queue_full && keep;

endmodule

FILE: rtl/lsp_queue.sv
`timescale 1ns / 1ps

module lsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lsp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output lsp_pkg::cmd_type head_cmd
);

   localparam int PtrW = (lsp_pkg::QUEUE_DEPTH > 1) ? $clog2(lsp_pkg::QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(lsp_pkg::QUEUE_DEPTH + 1);

   lsp_pkg::cmd_type slot_ff [lsp_pkg::QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(lsp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(lsp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   assign full       = (count_ff == CntW'(lsp_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset) pop |-> count_ff != '0)
      else $error("queue popped while empty");
   assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff != CntW'(lsp_pkg::QUEUE_DEPTH))
      else $error("queue pushed while full");
   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");

endmodule

FILE: rtl/lsp_mod.sv
`timescale 1ns / 1ps

module lsp_mod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lsp_pkg::SEEK_BITS-1:0]  dividend,
   input  logic [lsp_pkg::LEN_BITS-1:0]   divisor,
   output logic                           done,
   output logic [lsp_pkg::LEN_BITS-1:0]   remainder
);

   localparam int CntW = $clog2(lsp_pkg::SEEK_BITS);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [CntW-1:0]                cnt_ff, cnt_in;
   logic [lsp_pkg::SEEK_BITS-1:0]  num_ff, num_in;
   logic [lsp_pkg::LEN_BITS-1:0]   rem_ff, rem_in;
   logic [lsp_pkg::LEN_BITS:0]     trial;
   logic [lsp_pkg::LEN_BITS:0]     diff;

   // restoring remainder, one dividend bit per cycle
   assign trial = {rem_ff, num_ff[lsp_pkg::SEEK_BITS-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(lsp_pkg::SEEK_BITS - 1);
         num_in  = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[lsp_pkg::SEEK_BITS-2:0], 1'b0};
         rem_in = (trial >= {1'b0, divisor}) ? diff[lsp_pkg::LEN_BITS-1:0]
                                             : trial[lsp_pkg::LEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("remainder unit restarted while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> rem_ff < divisor)
      else $error("remainder not below loop length");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("done without a run");

endmodule

FILE: rtl/lsp_back.sv
`timescale 1ns / 1ps

module lsp_back #(
   parameter int STORE_WORDS = lsp_pkg::DEF_STORE_WORDS,
   parameter int SAMPLE_BITS = lsp_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsp_pkg::cfg_type                  cfg,
   input  logic                              q_valid,
   input  lsp_pkg::cmd_type                  q_cmd,
   output logic                              q_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lsp_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int AW    = $clog2(STORE_WORDS);
   localparam int WideW = (AW > lsp_pkg::LEN_BITS) ? AW : lsp_pkg::LEN_BITS;
   localparam int ProdW = SAMPLE_BITS + 16;
   localparam int ShW   = SAMPLE_BITS + 3;
   localparam int SumW  = ((ShW > lsp_pkg::MIX_BITS) ? ShW : lsp_pkg::MIX_BITS) + 1;
   localparam int PW    = lsp_pkg::POS_BITS;
   localparam int LW    = lsp_pkg::LEN_BITS;

   lsp_pkg::back_state_type state_ff, state_in;

   logic [PW-1:0]                    play_pos_ff, play_pos_in;
   logic [PW-1:0]                    cur_pos_ff, cur_pos_in;
   logic                             seek_neg_ff, seek_neg_in;
   logic signed [lsp_pkg::MIX_BITS-1:0] left_mix_ff, left_mix_in;
   logic signed [lsp_pkg::MIX_BITS-1:0] right_mix_ff, right_mix_in;
   logic signed [SAMPLE_BITS-1:0]    left_smp_ff, left_smp_in;
   logic signed [ProdW-1:0]          prod_l_ff, prod_l_in;
   logic signed [ProdW-1:0]          prod_r_ff, prod_r_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lsp_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                             mod_start;
   logic [lsp_pkg::SEEK_BITS-1:0]    mod_dividend;
   logic                             mod_done;
   logic [LW-1:0]                    mod_rem;

   logic                             wr_en;
   logic [WideW-1:0]                 wr_wide;
   logic [lsp_pkg::MAX_SAMPLE_BITS-1:0] smp_ext;
   logic [PW-1:0]                    rd_pos;
   logic                             rd_odd;
   logic [WideW-1:0]                 rd_wide;
   logic [WideW-1:0]                 rd_addr_wide;
   logic [SAMPLE_BITS-1:0]           rd_data;
   logic signed [SAMPLE_BITS-1:0]    rd_smp;
   logic signed [15:0]               gain_s;

   logic signed [ProdW:0]            rnd_l, rnd_r, shr_l, shr_r;
   logic signed [SumW-1:0]           sum_l, sum_r;
   logic [lsp_pkg::MIX_BITS-1:0]     sat_l, sat_r;
   logic                             slot_free;
   logic                             mix_fire;
   logic [LW-1:0]                    pos_inc;

   lsp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (mod_dividend),
      .divisor   (cfg.loop_len),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   lsp_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_wide[AW-1:0]),
      .wr_data (smp_ext[SAMPLE_BITS-1:0]),
      .rd_addr (rd_addr_wide[AW-1:0]),
      .rd_data (rd_data)
   );

   assign wr_wide = WideW'(q_cmd.load_address);
   assign smp_ext = {{(lsp_pkg::MAX_SAMPLE_BITS-16){q_cmd.load_sample[15]}},
                     q_cmd.load_sample};

   // stereo frames sit as left/right word pairs
   assign rd_wide      = WideW'(rd_pos);
   assign rd_addr_wide = cfg.stereo_mode ? {rd_wide[WideW-2:0], rd_odd} : rd_wide;
   assign rd_smp       = $signed(rd_data);
   assign gain_s       = $signed({1'b0, cfg.gain});

   // scale with round half up, then saturating mix
   assign rnd_l = (ProdW+1)'(prod_l_ff) + (ProdW+1)'(lsp_pkg::ROUND_HALF);
   assign rnd_r = (ProdW+1)'(prod_r_ff) + (ProdW+1)'(lsp_pkg::ROUND_HALF);
   assign shr_l = rnd_l >>> lsp_pkg::GAIN_FRAC;
   assign shr_r = rnd_r >>> lsp_pkg::GAIN_FRAC;
   assign sum_l = SumW'(shr_l) + SumW'(left_mix_ff);
   assign sum_r = SumW'(shr_r) + SumW'(right_mix_ff);

   always_comb begin
      if (sum_l > SumW'(lsp_pkg::MIX_MAX)) begin
         sat_l = lsp_pkg::MIX_BITS'(lsp_pkg::MIX_MAX);
      end else if (sum_l < SumW'(lsp_pkg::MIX_MIN)) begin
         sat_l = lsp_pkg::MIX_BITS'(lsp_pkg::MIX_MIN);
      end else begin
         sat_l = sum_l[lsp_pkg::MIX_BITS-1:0];
      end
      if (sum_r > SumW'(lsp_pkg::MIX_MAX)) begin
         sat_r = lsp_pkg::MIX_BITS'(lsp_pkg::MIX_MAX);
      end else if (sum_r < SumW'(lsp_pkg::MIX_MIN)) begin
         sat_r = lsp_pkg::MIX_BITS'(lsp_pkg::MIX_MIN);
      end else begin
         sat_r = sum_r[lsp_pkg::MIX_BITS-1:0];
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign mix_fire  = (state_ff == lsp_pkg::ST_MIX) && slot_free;
   assign pos_inc   = LW'(cur_pos_ff) + 1'b1;

   always_comb begin
      state_in     = state_ff;
      play_pos_in  = play_pos_ff;
      cur_pos_in   = cur_pos_ff;
      seek_neg_in  = seek_neg_ff;
      left_mix_in  = left_mix_ff;
      right_mix_in = right_mix_ff;
      left_smp_in  = left_smp_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      q_pop        = 1'b0;
      mod_start    = 1'b0;
      mod_dividend = lsp_pkg::SEEK_BITS'(play_pos_ff);
      wr_en        = 1'b0;
      rd_pos       = cur_pos_ff;
      rd_odd       = 1'b0;
      case (state_ff)
         lsp_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  lsp_pkg::CMD_LOAD: begin
                     wr_en = 1'b1;
                  end
                  lsp_pkg::CMD_SEEK: begin
                     mod_start    = 1'b1;
                     mod_dividend = q_cmd.seek_mag;
                     seek_neg_in  = q_cmd.seek_neg;
                     state_in     = lsp_pkg::ST_SEEK;
                  end
                  lsp_pkg::CMD_RENDER: begin
                     left_mix_in  = q_cmd.left_mix;
                     right_mix_in = q_cmd.right_mix;
                     if (LW'(play_pos_ff) >= cfg.loop_len) begin
                        mod_start = 1'b1;
                        state_in  = lsp_pkg::ST_WRAP;
                     end else begin
                        cur_pos_in = play_pos_ff;
                        rd_pos     = play_pos_ff;
                        state_in   = lsp_pkg::ST_RD_R;
                     end
                  end
                  default: begin
                     state_in = lsp_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         lsp_pkg::ST_SEEK: begin
            if (mod_done) begin
               // true modulo for negative positions
               play_pos_in = (seek_neg_ff && mod_rem != '0) ? PW'(cfg.loop_len - mod_rem)
                                                            : mod_rem[PW-1:0];
               state_in    = lsp_pkg::ST_IDLE;
            end
         end
         lsp_pkg::ST_WRAP: begin
            if (mod_done) begin
               cur_pos_in = mod_rem[PW-1:0];
               state_in   = lsp_pkg::ST_RD_L;
            end
         end
         lsp_pkg::ST_RD_L: begin
            state_in = lsp_pkg::ST_RD_R;
         end
         lsp_pkg::ST_RD_R: begin
            rd_odd      = 1'b1;
            left_smp_in = rd_smp;
            state_in    = lsp_pkg::ST_MUL;
         end
         lsp_pkg::ST_MUL: begin
            prod_l_in = left_smp_ff * gain_s;
            prod_r_in = (cfg.stereo_mode ? rd_smp : left_smp_ff) * gain_s;
            state_in  = lsp_pkg::ST_MIX;
         end
         lsp_pkg::ST_MIX: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {cur_pos_ff, sat_r, sat_l};
               if (cfg.reverse_play) begin
                  play_pos_in = (cur_pos_ff == '0) ? PW'(cfg.loop_len - 1'b1)
                                                   : cur_pos_ff - 1'b1;
               end else begin
                  play_pos_in = (pos_inc >= cfg.loop_len) ? '0 : pos_inc[PW-1:0];
               end
               state_in = lsp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lsp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsp_pkg::ST_IDLE;
         play_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         play_pos_ff  <= play_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_pos_ff   <= cur_pos_in;
      seek_neg_ff  <= seek_neg_in;
      left_mix_ff  <= left_mix_in;
      right_mix_ff <= right_mix_in;
      left_smp_ff  <= left_smp_in;
      prod_l_ff    <= prod_l_in;
      prod_r_ff    <= prod_r_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == lsp_pkg::ST_RD_R |-> LW'(cur_pos_ff) < cfg.loop_len)
      else $error("render reads outside the loop");
   assert property (@(posedge clock) disable iff (reset)
      mix_fire |=> LW'(play_pos_ff) < cfg.loop_len)
      else $error("position stepped outside the loop");
   assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == lsp_pkg::ST_SEEK || state_ff == lsp_pkg::ST_WRAP))
      else $error("remainder finished with nobody waiting");

endmodule

FILE: rtl/loop_sample_player_top.sv
`timescale 1ns / 1ps

// channel | dir | ports                    | contents
// req     | in  | req_tvalid/tready/tdata  | one load, render or seek transaction
// rsp     | out | rsp_tvalid/tready/tdata  | one mixed frame per render
// csr     | in  | csr_we/index/wdata       | register write, no read-back
//
// render takes a longer path when the position lies at or past the loop end, and
// seek always does. both long paths go through the 24-step remainder unit, one
// dividend bit a cycle; render reads the store port twice.
// synchronous reset clears control state, csrs and position; the sample store is not cleared.
// a 2-entry queue lets input transactions pile up while the back end is busy;
// a held result stalls the next render at its mix, and every command behind it.

module loop_sample_player_top #(
   parameter int STORE_WORDS = lsp_pkg::DEF_STORE_WORDS,
   parameter int SAMPLE_BITS = lsp_pkg::DEF_SAMPLE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // load_address, load_sample, seek_position, left_mix_in, right_mix_in
   input  logic [lsp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // operation
   input  logic [lsp_pkg::OP_BITS-1:0]         req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // left_mix_out, right_mix_out, frame_position
   output logic [lsp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                csr_we,
   input  logic [lsp_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [lsp_pkg::LEN_BITS-1:0]        csr_wdata
);

   localparam int CmpW = ($clog2(STORE_WORDS) + 2 > 18) ? $clog2(STORE_WORDS) + 2 : 18;

   logic                            stereo_ff;
   logic [lsp_pkg::LEN_BITS-1:0]    loop_frames_ff;
   logic                            reverse_ff;
   logic [lsp_pkg::GAIN_BITS-1:0]   gain_ff;

   logic [CmpW-1:0]                 len_raw;
   logic [CmpW-1:0]                 len_nz;
   logic [CmpW-1:0]                 len_cap;
   logic [CmpW-1:0]                 frames;
   logic [CmpW-1:0]                 len_fit;
   lsp_pkg::cfg_type                cfg;

   logic                            push;
   lsp_pkg::cmd_type                push_cmd;
   logic                            q_full;
   logic                            q_valid;
   lsp_pkg::cmd_type                q_cmd;
   logic                            q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff      <= 1'b0;
         loop_frames_ff <= lsp_pkg::LOOP_RESET;
         reverse_ff     <= 1'b0;
         gain_ff        <= lsp_pkg::GAIN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lsp_pkg::CSR_STEREO:  stereo_ff      <= csr_wdata[0];
            lsp_pkg::CSR_LOOP:    loop_frames_ff <= csr_wdata;
            lsp_pkg::CSR_REVERSE: reverse_ff     <= csr_wdata[0];
            lsp_pkg::CSR_GAIN:    gain_ff        <= csr_wdata[lsp_pkg::GAIN_BITS-1:0];
            default: begin
               stereo_ff <= stereo_ff;
            end
         endcase
      end
   end

   // effective loop length: at least one frame, capped at MAX_LOOP and by the store
   assign len_raw = CmpW'(loop_frames_ff);
   assign len_nz  = (len_raw == '0) ? CmpW'(1) : len_raw;
   assign len_cap = (len_nz > CmpW'(lsp_pkg::MAX_LOOP)) ? CmpW'(lsp_pkg::MAX_LOOP) : len_nz;
   assign frames  = stereo_ff ? CmpW'(STORE_WORDS / 2) : CmpW'(STORE_WORDS);
   assign len_fit = (len_cap > frames) ? frames : len_cap;

   assign cfg.stereo_mode  = stereo_ff;
   assign cfg.reverse_play = reverse_ff;
   assign cfg.gain         = gain_ff;
   assign cfg.loop_len     = len_fit[lsp_pkg::LEN_BITS-1:0];

   lsp_front #(
      .STORE_WORDS (STORE_WORDS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (q_full),
      .push       (push),
      .cmd        (push_cmd)
   );

   lsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (q_cmd)
   );

   lsp_back #(
      .STORE_WORDS (STORE_WORDS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
